// File: sv/mcsd_pkg.sv
package mcsd_pkg;

    // Command codes of an input beat.
    typedef enum logic [1:0] {
        CMD_DECODE      = 2'd0,
        CMD_LOAD_MODE   = 2'd1,
        CMD_CLEAR_SHIFT = 2'd2,
        CMD_NONE        = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_EVENT      = 3'd0,
        ST_STATE_ONLY = 3'd1,
        ST_RELEASE    = 3'd2,
        ST_INVALID    = 3'd3,
        ST_UNKNOWN    = 3'd4,
        ST_UNASSIGNED = 3'd5,
        ST_IGNORED    = 3'd6,
        ST_SPARE      = 3'd7
    } t_status;

    typedef enum logic [3:0] {
        EV_SET_MODE      = 4'd0,
        EV_SRC_ENCODER   = 4'd1,
        EV_LAYER_PAN     = 4'd2,
        EV_MONITOR_LEVEL = 4'd3,
        EV_LAYER_LEVEL   = 4'd4,
        EV_MASTER_LEVEL  = 4'd5,
        EV_SRC_PREV      = 4'd6,
        EV_SRC_NEXT      = 4'd7,
        EV_LAYER_PREV    = 4'd8,
        EV_LAYER_NEXT    = 4'd9,
        EV_SRC_BUTTON    = 4'd10,
        EV_SELECT_LAYER  = 4'd11,
        EV_TOGGLE_MUTE   = 4'd12,
        EV_CAPTURE       = 4'd13,
        EV_CLEAR_LAYER   = 4'd14,
        EV_TOGGLE_MON    = 4'd15
    } t_kind;

    localparam logic [3:0] MSG_LENGTH    = 4'd3;
    localparam logic [3:0] STATUS_CC     = 4'hB;
    // Low nibble of the status byte; MIDI channels count from one.
    localparam logic [3:0] CH_SETUP      = 4'd6;
    localparam logic [3:0] CH_ENCODER    = 4'd15;
    localparam logic [3:0] CH_NAV        = 4'd0;

    localparam logic [6:0] CC_MODE       = 7'd30;
    localparam logic [6:0] CC_SHIFT      = 7'd63;
    localparam logic [6:0] CC_ENC_FIRST  = 7'd77;
    localparam logic [6:0] CC_ENC_LAST   = 7'd92;
    localparam logic [6:0] CC_BTN_FIRST  = 7'd37;
    localparam logic [6:0] CC_BTN_LAST   = 7'd44;
    localparam logic [6:0] CC_SRC_PREV   = 7'd106;
    localparam logic [6:0] CC_SRC_NEXT   = 7'd107;
    localparam logic [6:0] CC_LAYER_PREV = 7'd103;
    localparam logic [6:0] CC_LAYER_NEXT = 7'd102;
    localparam logic [6:0] VAL_PRESS     = 7'd127;
    localparam logic [6:0] VAL_RELEASE   = 7'd0;
    localparam logic [6:0] VAL_MIXER     = 7'd1;
    localparam logic [6:0] VAL_CONTROL   = 7'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic        new_mode;
        logic [3:0]  msg_length;
        logic [7:0]  status_byte;
        logic [7:0]  controller_byte;
        logic [7:0]  value_byte;
        logic [31:0] sample_pos;
        logic [63:0] ingress_seq;
    } t_in_item;

    typedef struct packed {
        t_status     result_status;
        logic        event_valid;
        t_kind       event_kind;
        logic [3:0]  event_index;
        logic [6:0]  event_amount;
        logic [31:0] event_offset;
        logic [63:0] event_seq;
        logic        mode_now;
        logic        shift_now;
    } t_out_item;

    // Decoder verdict handed to the pipeline control.
    typedef struct packed {
        logic      has_result;
        logic      next_mode;
        logic      next_shift;
        t_out_item item;
    } t_dec_res;

endpackage

// File: sv/mcsd_if.sv
interface mcsd_in_if;
    import mcsd_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface mcsd_out_if;
    import mcsd_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

// File: sv/mcsd_decode.sv
module mcsd_decode (
    input  mcsd_pkg::t_in_item i_item,
    input  logic               i_mode,
    input  logic               i_shift,
    output mcsd_pkg::t_dec_res o_res
);
    import mcsd_pkg::*;

    logic       malformed;
    logic [6:0] cc;
    logic [6:0] val;
    logic       press;
    logic       rel;
    logic [6:0] enc_off;
    logic [3:0] enc_slot;
    logic [6:0] btn_off;
    logic [2:0] btn_slot;
    logic       is_nav;
    logic       ev;
    t_kind      kind;
    logic [3:0] idx;
    logic [6:0] ev_val;
    t_status    status;
    logic       next_mode;
    logic       next_shift;

    assign cc       = i_item.controller_byte[6:0];
    assign val      = i_item.value_byte[6:0];
    assign press    = (val == VAL_PRESS);
    assign rel      = (val == VAL_RELEASE);
    assign enc_off  = cc - CC_ENC_FIRST;
    assign enc_slot = enc_off[3:0];
    assign btn_off  = cc - CC_BTN_FIRST;
    assign btn_slot = btn_off[2:0];
    assign is_nav   = (cc == CC_SRC_PREV) || (cc == CC_SRC_NEXT)
                   || (cc == CC_LAYER_PREV) || (cc == CC_LAYER_NEXT);
    assign malformed = (i_item.msg_length != MSG_LENGTH)
                    || (i_item.status_byte[7:4] != STATUS_CC)
                    || i_item.controller_byte[7] || i_item.value_byte[7];

    always_comb begin
        status     = ST_STATE_ONLY;
        ev         = 1'b0;
        kind       = EV_SET_MODE;
        idx        = '0;
        ev_val     = '0;
        next_mode  = i_mode;
        next_shift = i_shift;
        case (i_item.command)
            CMD_LOAD_MODE: begin
                next_mode = i_item.new_mode;
            end
            CMD_CLEAR_SHIFT: begin
                next_shift = 1'b0;
            end
            CMD_DECODE: begin
                if (malformed) begin
                    status = ST_INVALID;
                end else if (i_item.status_byte[3:0] == CH_SETUP) begin
                    if (cc == CC_SHIFT) begin
                        if (press || rel) begin
                            next_shift = press;
                        end else begin
                            status = ST_INVALID;
                        end
                    end else if (cc == CC_MODE) begin
                        if (val == VAL_MIXER || val == VAL_CONTROL) begin
                            next_mode = (val == VAL_CONTROL);
                            ev        = 1'b1;
                            kind      = EV_SET_MODE;
                            idx       = {3'b000, next_mode};
                        end else begin
                            status = ST_INVALID;
                        end
                    end else begin
                        status = ST_UNKNOWN;
                    end
                end else if (i_item.status_byte[3:0] == CH_ENCODER) begin
                    if (cc < CC_ENC_FIRST || cc > CC_ENC_LAST) begin
                        status = ST_UNKNOWN;
                    end else if (i_mode) begin
                        ev     = 1'b1;
                        kind   = EV_SRC_ENCODER;
                        idx    = enc_slot;
                        ev_val = val;
                    end else if (enc_slot < 4'd3) begin
                        ev     = 1'b1;
                        kind   = EV_LAYER_PAN;
                        idx    = enc_slot;
                        ev_val = val;
                    end else if (enc_slot == 4'd3) begin
                        ev     = 1'b1;
                        kind   = EV_MONITOR_LEVEL;
                        ev_val = val;
                    end else if (enc_slot >= 4'd8 && enc_slot < 4'd11) begin
                        ev     = 1'b1;
                        kind   = EV_LAYER_LEVEL;
                        idx    = enc_slot - 4'd8;
                        ev_val = val;
                    end else if (enc_slot == 4'd11) begin
                        ev     = 1'b1;
                        kind   = EV_MASTER_LEVEL;
                        ev_val = val;
                    end else begin
                        status = ST_UNASSIGNED;
                    end
                end else if (i_item.status_byte[3:0] != CH_NAV) begin
                    status = ST_IGNORED;
                end else if (is_nav) begin
                    if (rel) begin
                        status = ST_RELEASE;
                    end else if (!press) begin
                        status = ST_INVALID;
                    end else begin
                        ev = 1'b1;
                        if (cc == CC_SRC_PREV) begin
                            kind = EV_SRC_PREV;
                        end else if (cc == CC_SRC_NEXT) begin
                            kind = EV_SRC_NEXT;
                        end else if (cc == CC_LAYER_PREV) begin
                            kind = EV_LAYER_PREV;
                        end else begin
                            kind = EV_LAYER_NEXT;
                        end
                    end
                end else if (cc < CC_BTN_FIRST || cc > CC_BTN_LAST) begin
                    status = ST_UNKNOWN;
                end else if (i_mode) begin
                    if (press || rel) begin
                        ev     = 1'b1;
                        kind   = EV_SRC_BUTTON;
                        idx    = {1'b0, btn_slot};
                        ev_val = val;
                    end else begin
                        status = ST_INVALID;
                    end
                end else if (rel) begin
                    status = ST_RELEASE;
                end else if (!press) begin
                    status = ST_INVALID;
                end else begin
                    ev = 1'b1;
                    if (btn_slot < 3'd3) begin
                        kind = EV_SELECT_LAYER;
                        idx  = {1'b0, btn_slot};
                    end else if (btn_slot < 3'd6) begin
                        kind = EV_TOGGLE_MUTE;
                        idx  = {1'b0, btn_slot - 3'd3};
                    end else if (btn_slot == 3'd6) begin
                        kind = EV_CAPTURE;
                    end else if (i_shift) begin
                        kind = EV_CLEAR_LAYER;
                    end else begin
                        kind = EV_TOGGLE_MON;
                    end
                end
            end
            default: begin
                status = ST_STATE_ONLY;
            end
        endcase
    end

    always_comb begin
        o_res.has_result         = (i_item.command != CMD_NONE);
        o_res.next_mode          = next_mode;
        o_res.next_shift         = next_shift;
        o_res.item.result_status = ev ? ST_EVENT : status;
        o_res.item.event_valid   = ev;
        o_res.item.event_kind    = ev ? kind : EV_SET_MODE;
        o_res.item.event_index   = ev ? idx : 4'd0;
        o_res.item.event_amount  = ev ? ev_val : 7'd0;
        o_res.item.event_offset  = ev ? i_item.sample_pos : 32'd0;
        o_res.item.event_seq     = ev ? i_item.ingress_seq : 64'd0;
        o_res.item.mode_now      = next_mode;
        o_res.item.shift_now     = next_shift;
    end

endmodule

// File: sv/midi_cc_surface_event_decoder_unit.sv
// Control-change decoder for a MIDI control surface.
//
// Input beats arrive on i_msg: a command, a three-byte control-change message
// and two tags. Commands other than the unused code each give exactly one
// result beat on o_evt: a status, an optional event (kind, index, value and
// the copied tags) and the surface mode and shift flag after the beat. The
// unused command code is consumed without producing a result.
//
// The datapath is two register stages. A beat accepted into the input
// register is decoded by shallow compare logic and lands in the output
// register, which drives o_evt.valid. A new beat is taken every cycle
// unless a result waits in the input register behind a stalled output.
//
// The mode and shift flags live in flip-flops updated as a beat moves from
// the input register to the output register, so each beat is decoded
// against the state left by the one before it.
// Synchronous active-low reset clears both flags (mixer mode, shift off)
// and empties both stages. When the receiver holds o_evt.ready low the
// output register keeps its beat, the input register fills, and then
// i_msg.ready drops until the receiver takes the waiting result.
module midi_cc_surface_event_decoder_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mcsd_in_if.sink          i_msg,
    mcsd_out_if.source       o_evt
);
    import mcsd_pkg::*;

    logic      r_s1_valid;
    logic      n_s1_valid;
    t_in_item  r_s1_item;
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out_item;
    logic      r_mode;
    logic      n_mode;
    logic      r_shift;
    logic      n_shift;

    t_dec_res  dec;
    logic      out_free;
    logic      s1_adv;
    logic      in_take;

    mcsd_decode u_decode (
        .i_item  (r_s1_item),
        .i_mode  (r_mode),
        .i_shift (r_shift),
        .o_res   (dec)
    );

    // The output register can take a new result when empty or being drained.
    // A beat that yields no result leaves the input stage regardless.
    assign out_free    = !r_out_valid || o_evt.ready;
    assign s1_adv      = r_s1_valid && (out_free || !dec.has_result);
    assign in_take     = i_msg.valid && i_msg.ready;
    assign i_msg.ready = !r_s1_valid || s1_adv;

    assign o_evt.valid = r_out_valid;
    assign o_evt.item  = r_out_item;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_take) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (s1_adv && dec.has_result) begin
            n_out_valid = 1'b1;
        end else if (o_evt.ready) begin
            n_out_valid = 1'b0;
        end

        n_mode  = s1_adv ? dec.next_mode : r_mode;
        n_shift = s1_adv ? dec.next_shift : r_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= 1'b0;
            r_shift     <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            r_mode      <= n_mode;
            r_shift     <= n_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_item <= i_msg.item;
        end
        if (s1_adv && dec.has_result) begin
            r_out_item <= dec.item;
        end
    end

    // A result reports the flags that its own beat left behind.
    a_state_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && dec.has_result) |=>
            (r_out_item.mode_now == r_mode && r_out_item.shift_now == r_shift))
        else $error("result flags differ from stored surface state");

    // The flags only move when a beat leaves the input stage.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_adv |=> ($stable(r_mode) && $stable(r_shift)))
        else $error("surface state changed without a beat");

    // The event flag and the event status always agree.
    a_event_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |->
            (r_out_item.event_valid == (r_out_item.result_status == ST_EVENT)))
        else $error("event flag and status disagree");

    // A beat without an event carries cleared tags.
    a_no_event_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_item.event_valid) |->
            (r_out_item.event_offset == 32'd0 && r_out_item.event_seq == 64'd0
             && r_out_item.event_amount == 7'd0 && r_out_item.event_index == 4'd0))
        else $error("event fields not cleared on a non-event result");

    // A stalled result stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_evt.ready) |=> (r_out_valid && $stable(r_out_item)))
        else $error("output register changed while stalled");

endmodule
